// ===== rtl/core/cpa_pkg.sv =====
// Shared constants, codes and transaction types of the call profile accumulator.
`default_nettype none

package cpa_pkg;

    localparam int NUM_FUNCS  = 256;
    localparam int CALL_DEPTH = 64;

    localparam int FUNC_W  = 8;
    localparam int TS_W    = 64;
    localparam int CALLS_W = 32;
    localparam int STAT_W  = 3;
    localparam int REQ_W   = 2;
    localparam int DEPTH_W = 7;

    localparam int FUNC_AW = $clog2(NUM_FUNCS);
    localparam int STK_AW  = $clog2(CALL_DEPTH);
    localparam int TOP_W   = $clog2(CALL_DEPTH + 1);

    localparam int S_TDATA_W = ((FUNC_W + TS_W + 7) / 8) * 8;
    localparam int M_RES_W   = CALLS_W + 2 * TS_W + DEPTH_W;
    localparam int M_TDATA_W = ((M_RES_W + 7) / 8) * 8;

    localparam logic [CALLS_W-1:0] CALLS_MAX = '1;

    typedef enum logic [REQ_W-1:0] {
        EV_ENTER    = 2'd0,
        EV_EXIT     = 2'd1,
        EV_REGISTER = 2'd2,
        EV_INVALID  = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_UNKNOWN  = 3'd1,
        STAT_INVALID  = 3'd2,
        STAT_NESTING  = 3'd3,
        STAT_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_EXA,
        ST_EXB,
        ST_EXP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [CALLS_W-1:0] calls;
        logic [TS_W-1:0]    incl;
        logic [TS_W-1:0]    child;
    } t_tbl_entry;

    typedef struct packed {
        logic               wr_en;
        logic [FUNC_AW-1:0] wr_addr;
        t_tbl_entry         wr_data;
        logic [FUNC_AW-1:0] rd_addr;
    } t_tbl_req;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TS_W-1:0]   start;
    } t_stk_entry;

    typedef struct packed {
        logic              wr_en;
        logic [STK_AW-1:0] addr;
        t_stk_entry        wr_data;
    } t_stk_req;

endpackage

`default_nettype wire

// ===== rtl/core/cpa_func_table.sv =====
// Per-function counter memory: one write port, one registered read port.
`default_nettype none

module cpa_func_table (
    input  wire                   i_clk,
    input  cpa_pkg::t_tbl_req     i_req,
    output cpa_pkg::t_tbl_entry   o_rd_data
);

    cpa_pkg::t_tbl_entry mem [cpa_pkg::NUM_FUNCS];
    cpa_pkg::t_tbl_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/cpa_path_stack.sv =====
// Call-path stack memory: single port, registered read.
`default_nettype none

module cpa_path_stack (
    input  wire                   i_clk,
    input  cpa_pkg::t_stk_req     i_req,
    output cpa_pkg::t_stk_entry   o_rd_data
);

    cpa_pkg::t_stk_entry mem [cpa_pkg::CALL_DEPTH];
    cpa_pkg::t_stk_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.addr] <= i_req.wr_data;
        end else begin
            r_rd_data <= mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/call_profile_accumulator.sv =====
// Top level: event sequencer, result register and the two state memories.
// Sequence: an accepted event is checked in ST_CHK and then goes to ST_OUT; an exit goes on
//   through ST_EXA and, when a parent remains, ST_EXB and ST_EXP before ST_OUT.
// Throughput: one event at a time; the next is taken only once the sequencer is back in idle,
//   after the read-modify-write passes through the function table and the stack memory.
// A finished result waits in the output register while the next event is taken.
// Reset (synchronous, active low) clears the known bits, the stack depth, the sequencer and the
//   output valid flag; counters are cleared by a register event, stack entries by a push.
`default_nettype none

module call_profile_accumulator (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [cpa_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // func_id, time_stamp
    input  wire  [cpa_pkg::REQ_W-1:0]       s_axis_tuser,  // req_type
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [cpa_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // call_count, inclusive_time,
                                                           // exclusive_time, path_depth, pad
    output logic [cpa_pkg::STAT_W-1:0]      m_axis_tuser   // status
);

    localparam int FUNC_AW = cpa_pkg::FUNC_AW;
    localparam int STK_AW  = cpa_pkg::STK_AW;
    localparam int TOP_W   = cpa_pkg::TOP_W;
    localparam int FUNC_W  = cpa_pkg::FUNC_W;
    localparam int TS_W    = cpa_pkg::TS_W;
    localparam int CALLS_W = cpa_pkg::CALLS_W;
    localparam int DEPTH_W = cpa_pkg::DEPTH_W;

    cpa_pkg::t_state   r_state, n_state;
    cpa_pkg::t_req     r_req, n_req;
    cpa_pkg::t_status  r_status, n_status;
    logic [FUNC_W-1:0] r_func, n_func;
    logic [FUNC_W-1:0] r_parent, n_parent;
    logic [TS_W-1:0]   r_ts, n_ts;
    logic [TOP_W-1:0]  r_top, n_top;
    logic [cpa_pkg::NUM_FUNCS-1:0] r_known, n_known;
    logic [TS_W-1:0]    r_elapsed, n_elapsed;
    logic [CALLS_W-1:0] r_calls, n_calls;
    logic [TS_W-1:0]    r_incl, n_incl;
    logic [TS_W-1:0]    r_child, n_child;

    logic                    r_out_valid, n_out_valid;
    cpa_pkg::t_status        r_out_status, n_out_status;
    logic [CALLS_W-1:0]      r_out_calls, n_out_calls;
    logic [TS_W-1:0]         r_out_incl, n_out_incl;
    logic [TS_W-1:0]         r_out_excl, n_out_excl;
    logic [DEPTH_W-1:0]      r_out_depth, n_out_depth;

    cpa_pkg::t_tbl_req   tbl_req;
    cpa_pkg::t_tbl_entry tbl_q;
    cpa_pkg::t_stk_req   stk_req;
    cpa_pkg::t_stk_entry stk_q;

    logic               func_ok;
    logic [FUNC_AW-1:0] f_idx;
    logic [TS_W-1:0]    child_sum;

    cpa_func_table u_func_table (
        .i_clk     (i_clk),
        .i_req     (tbl_req),
        .o_rd_data (tbl_q)
    );

    cpa_path_stack u_path_stack (
        .i_clk     (i_clk),
        .i_req     (stk_req),
        .o_rd_data (stk_q)
    );

    assign f_idx     = FUNC_AW'(r_func);
    assign func_ok   = (32'(r_func) < cpa_pkg::NUM_FUNCS);
    assign child_sum = tbl_q.child + r_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cpa_pkg::ST_IDLE;
            r_top       <= '0;
            r_known     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_known     <= n_known;
            r_out_valid <= n_out_valid;
        end
        r_req        <= n_req;
        r_status     <= n_status;
        r_func       <= n_func;
        r_parent     <= n_parent;
        r_ts         <= n_ts;
        r_elapsed    <= n_elapsed;
        r_calls      <= n_calls;
        r_incl       <= n_incl;
        r_child      <= n_child;
        r_out_status <= n_out_status;
        r_out_calls  <= n_out_calls;
        r_out_incl   <= n_out_incl;
        r_out_excl   <= n_out_excl;
        r_out_depth  <= n_out_depth;
    end

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_status     = r_status;
        n_func       = r_func;
        n_parent     = r_parent;
        n_ts         = r_ts;
        n_top        = r_top;
        n_known      = r_known;
        n_elapsed    = r_elapsed;
        n_calls      = r_calls;
        n_incl       = r_incl;
        n_child      = r_child;
        n_out_valid  = r_out_valid & ~m_axis_tready;
        n_out_status = r_out_status;
        n_out_calls  = r_out_calls;
        n_out_incl   = r_out_incl;
        n_out_excl   = r_out_excl;
        n_out_depth  = r_out_depth;

        tbl_req.wr_en   = 1'b0;
        tbl_req.wr_addr = f_idx;
        tbl_req.wr_data = '{calls: r_calls, incl: r_incl, child: r_child};
        tbl_req.rd_addr = FUNC_AW'(s_axis_tdata[FUNC_W-1:0]);

        // top-of-stack read by default; the same address gives the parent after a pop
        stk_req.wr_en   = 1'b0;
        stk_req.addr    = STK_AW'(r_top - TOP_W'(1));
        stk_req.wr_data = '{func: r_func, start: r_ts};

        s_axis_tready = (r_state == cpa_pkg::ST_IDLE);

        case (r_state)
            cpa_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_req   = cpa_pkg::t_req'(s_axis_tuser);
                    n_func  = s_axis_tdata[FUNC_W-1:0];
                    n_ts    = s_axis_tdata[FUNC_W +: TS_W];
                    n_state = cpa_pkg::ST_CHK;
                end
            end
            cpa_pkg::ST_CHK: begin
                n_elapsed = r_ts - stk_q.start;
                n_calls   = tbl_q.calls;
                n_incl    = tbl_q.incl;
                n_child   = tbl_q.child;
                n_state   = cpa_pkg::ST_OUT;
                case (r_req)
                    cpa_pkg::EV_REGISTER: begin
                        if (!func_ok) begin
                            n_status = cpa_pkg::STAT_UNKNOWN;
                        end else begin
                            n_status         = cpa_pkg::STAT_OK;
                            n_known[f_idx]   = 1'b1;
                            n_calls          = '0;
                            n_incl           = '0;
                            n_child          = '0;
                            tbl_req.wr_en    = 1'b1;
                            tbl_req.wr_data  = '0;
                        end
                    end
                    cpa_pkg::EV_ENTER: begin
                        if (!func_ok || !r_known[f_idx]) begin
                            n_status = cpa_pkg::STAT_UNKNOWN;
                        end else if (r_top >= TOP_W'(cpa_pkg::CALL_DEPTH)) begin
                            n_status = cpa_pkg::STAT_OVERFLOW;
                        end else begin
                            n_status      = cpa_pkg::STAT_OK;
                            stk_req.wr_en = 1'b1;
                            stk_req.addr  = STK_AW'(r_top);
                            n_top         = r_top + TOP_W'(1);
                            if (tbl_q.calls != cpa_pkg::CALLS_MAX) begin
                                n_calls = tbl_q.calls + CALLS_W'(1);
                            end
                            tbl_req.wr_en   = 1'b1;
                            tbl_req.wr_data = '{calls: n_calls, incl: tbl_q.incl,
                                                child: tbl_q.child};
                        end
                    end
                    cpa_pkg::EV_EXIT: begin
                        if (!func_ok || !r_known[f_idx]) begin
                            n_status = cpa_pkg::STAT_UNKNOWN;
                        end else if (r_top == '0 || r_top > TOP_W'(cpa_pkg::CALL_DEPTH)
                                     || stk_q.func != r_func) begin
                            n_status = cpa_pkg::STAT_NESTING;
                        end else begin
                            n_status = cpa_pkg::STAT_OK;
                            n_top    = r_top - TOP_W'(1);
                            n_state  = cpa_pkg::ST_EXA;
                        end
                    end
                    default: begin
                        n_status = cpa_pkg::STAT_INVALID;
                    end
                endcase
            end
            cpa_pkg::ST_EXA: begin
                n_incl          = r_incl + r_elapsed;
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_data = '{calls: r_calls, incl: n_incl, child: r_child};
                // stack read of the new top is issued here by the default address
                if (r_top != '0) begin
                    n_state = cpa_pkg::ST_EXB;
                end else begin
                    n_state = cpa_pkg::ST_OUT;
                end
            end
            cpa_pkg::ST_EXB: begin
                n_parent        = stk_q.func;
                tbl_req.rd_addr = FUNC_AW'(stk_q.func);
                n_state         = cpa_pkg::ST_EXP;
            end
            cpa_pkg::ST_EXP: begin
                // the function's own write landed before this read, so a recursive
                // parent sees the updated inclusive time
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = FUNC_AW'(r_parent);
                tbl_req.wr_data = '{calls: tbl_q.calls, incl: tbl_q.incl, child: child_sum};
                if (r_parent == r_func) begin
                    n_child = child_sum;
                end
                n_state = cpa_pkg::ST_OUT;
            end
            cpa_pkg::ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_depth  = DEPTH_W'(r_top);
                    if (r_status == cpa_pkg::STAT_OK) begin
                        n_out_calls = r_calls;
                        n_out_incl  = r_incl;
                        n_out_excl  = r_incl - r_child;
                    end else begin
                        n_out_calls = '0;
                        n_out_incl  = '0;
                        n_out_excl  = '0;
                    end
                    n_state = cpa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cpa_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = cpa_pkg::M_TDATA_W'({r_out_depth, r_out_excl, r_out_incl,
                                                r_out_calls});

endmodule

`default_nettype wire

// ===== rtl/core/cpa_checker.sv =====
// Port-level checks of the call profile accumulator, bound to the top level.
`default_nettype none

module cpa_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            s_axis_tvalid,
    input wire                            s_axis_tready,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [cpa_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input wire [cpa_pkg::STAT_W-1:0]      m_axis_tuser
);

    localparam int RES_W   = cpa_pkg::CALLS_W + 2 * cpa_pkg::TS_W;
    localparam int DEPTH_W = cpa_pkg::DEPTH_W;

    // a stalled result stays presented
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result dropped or changed while stalled");

    // one event in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction taken while one is in work");

    // refused events carry zero counters
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != cpa_pkg::STAT_OK |-> m_axis_tdata[RES_W-1:0] == '0)
        else $error("refused transaction with nonzero counters");

    // depth never exceeds the stack and status stays a defined code
    a_depth_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[RES_W +: DEPTH_W] <= DEPTH_W'(cpa_pkg::CALL_DEPTH)
            && m_axis_tuser <= cpa_pkg::STAT_OVERFLOW)
        else $error("depth or status out of range");

endmodule

bind call_profile_accumulator cpa_checker u_cpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking stream testbench for the call profile accumulator.
`timescale 1ns / 100ps

module testbench;

    localparam int NUM_FUNCS  = cpa_pkg::NUM_FUNCS;
    localparam int CALL_DEPTH = cpa_pkg::CALL_DEPTH;
    localparam int FUNC_W     = cpa_pkg::FUNC_W;
    localparam int TS_W       = cpa_pkg::TS_W;
    localparam int CALLS_W    = cpa_pkg::CALLS_W;
    localparam int STAT_W     = cpa_pkg::STAT_W;
    localparam int REQ_W      = cpa_pkg::REQ_W;
    localparam int DEPTH_W    = cpa_pkg::DEPTH_W;
    localparam int S_TDATA_W  = cpa_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = cpa_pkg::M_TDATA_W;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_EVENTS  = 470;
    localparam int TAIL_EVENTS    = 80;

    typedef struct {
        cpa_pkg::t_status   status;
        logic [CALLS_W-1:0] calls;
        logic [TS_W-1:0]    incl;
        logic [TS_W-1:0]    excl;
        logic [DEPTH_W-1:0] depth;
    } t_profile_result;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;  // func_id, time_stamp
    logic [REQ_W-1:0]       s_axis_tuser  = '0;  // req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;        // call_count, inclusive_time,
                                                 // exclusive_time, path_depth, pad
    logic [STAT_W-1:0]      m_axis_tuser;        // status

    // Profile tables and call-path stack as the block should hold them
    bit                 func_is_known [NUM_FUNCS];
    logic [CALLS_W-1:0] func_call_cnt [NUM_FUNCS];
    logic [TS_W-1:0]    func_incl_ticks [NUM_FUNCS];
    logic [TS_W-1:0]    func_child_ticks [NUM_FUNCS];
    logic [FUNC_W-1:0]  path_func_ids [CALL_DEPTH];
    logic [TS_W-1:0]    path_enter_ticks [CALL_DEPTH];
    int unsigned        path_level;

    t_profile_result    expected_profiles [$];
    logic [FUNC_W-1:0]  registered_ids [$];
    logic [TS_W-1:0]    trace_tick;
    int                 mismatches   = 0;
    int                 idle_cycles  = 0;
    int                 stall_left   = 0;
    bit                 sender_gaps  = 1'b1;
    bit                 sink_stalls  = 1'b1;

    call_profile_accumulator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Applies one trace event to the expected state and returns the result it yields.
    function automatic t_profile_result profile_event(cpa_pkg::t_req req,
                                                      logic [FUNC_W-1:0] fid,
                                                      logic [TS_W-1:0] ts);
        t_profile_result res;
        logic [TS_W-1:0] elapsed;
        res.status = cpa_pkg::STAT_OK;
        if (req == cpa_pkg::EV_INVALID) begin
            res.status = cpa_pkg::STAT_INVALID;
        end else if (req == cpa_pkg::EV_REGISTER) begin
            func_is_known[fid]    = 1'b1;
            func_call_cnt[fid]    = '0;
            func_incl_ticks[fid]  = '0;
            func_child_ticks[fid] = '0;
        end else if (!func_is_known[fid]) begin
            res.status = cpa_pkg::STAT_UNKNOWN;
        end else if (req == cpa_pkg::EV_ENTER) begin
            if (path_level >= CALL_DEPTH) begin
                res.status = cpa_pkg::STAT_OVERFLOW;
            end else begin
                path_func_ids[path_level]    = fid;
                path_enter_ticks[path_level] = ts;
                path_level++;
                if (func_call_cnt[fid] != cpa_pkg::CALLS_MAX)
                    func_call_cnt[fid]++;
            end
        end else if (path_level == 0 || path_func_ids[path_level-1] != fid) begin
            res.status = cpa_pkg::STAT_NESTING;
        end else begin
            elapsed = ts - path_enter_ticks[path_level-1];
            func_incl_ticks[fid] += elapsed;
            path_level--;
            if (path_level != 0)
                func_child_ticks[path_func_ids[path_level-1]] += elapsed;
        end
        if (res.status == cpa_pkg::STAT_OK) begin
            res.calls = func_call_cnt[fid];
            res.incl  = func_incl_ticks[fid];
            res.excl  = func_incl_ticks[fid] - func_child_ticks[fid];
        end else begin
            res.calls = '0;
            res.incl  = '0;
            res.excl  = '0;
        end
        res.depth = DEPTH_W'(path_level);
        return res;
    endfunction

    function automatic void check_field(string name, logic [TS_W-1:0] want,
                                        logic [TS_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Drives one event; called at a rising edge, returns at the edge it is accepted.
    task automatic send_event(cpa_pkg::t_req req, logic [FUNC_W-1:0] fid,
                              logic [TS_W-1:0] ts);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ts, fid};
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_profiles.insert(expected_profiles.size(), profile_event(req, fid, ts));
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_profiles.size() != 0);
    endtask

    function automatic void advance_tick();
        if ($urandom_range(0, 29) == 0)
            trace_tick = {$urandom, $urandom};
        else
            trace_tick += TS_W'($urandom_range(0, 5000));
    endfunction

    task automatic register_func(logic [FUNC_W-1:0] fid);
        if (!func_is_known[fid])
            registered_ids.insert(registered_ids.size(), fid);
        send_event(cpa_pkg::EV_REGISTER, fid, trace_tick);
    endtask

    // Mostly well-formed enter/exit nesting, some registrations, some noise.
    task automatic random_event();
        int pick;
        logic [FUNC_W-1:0] fid;
        pick = $urandom_range(0, 99);
        advance_tick();
        if (pick < 6 || registered_ids.size() == 0) begin
            register_func(FUNC_W'($urandom_range(0, NUM_FUNCS - 1)));
        end else if (pick < 16) begin
            send_event(cpa_pkg::t_req'($urandom_range(0, 3)),
                       FUNC_W'($urandom_range(0, NUM_FUNCS - 1)), {$urandom, $urandom});
        end else if (path_level > 0 && $urandom_range(0, 99) < 40 + path_level) begin
            send_event(cpa_pkg::EV_EXIT, path_func_ids[path_level-1], trace_tick);
        end else begin
            fid = registered_ids[$urandom_range(0, registered_ids.size() - 1)];
            send_event(cpa_pkg::EV_ENTER, fid, trace_tick);
        end
    endtask

    task automatic test_refused_events();
        send_event(cpa_pkg::EV_INVALID, 8'hFF, '1);
        send_event(cpa_pkg::EV_INVALID, 8'h00, '0);
        send_event(cpa_pkg::EV_ENTER, 8'h5A, 64'h0000_0000_0000_1000);
        send_event(cpa_pkg::EV_EXIT, 8'hA5, 64'h0000_0000_0000_2000);
    endtask

    task automatic test_nesting();
        register_func(8'h00);
        register_func(8'hFF);
        send_event(cpa_pkg::EV_EXIT, 8'h00, 64'd5);            // exit on an empty stack
        send_event(cpa_pkg::EV_ENTER, 8'h00, 64'd0);
        send_event(cpa_pkg::EV_ENTER, 8'hFF, 64'd100);
        send_event(cpa_pkg::EV_EXIT, 8'h00, 64'd150);          // not the stack top
        send_event(cpa_pkg::EV_EXIT, 8'hFF, 64'd400);
        send_event(cpa_pkg::EV_EXIT, 8'h00, 64'd1000);
        // elapsed time wraps through zero
        send_event(cpa_pkg::EV_ENTER, 8'hFF, 64'hFFFF_FFFF_FFFF_FFF6);
        send_event(cpa_pkg::EV_EXIT, 8'hFF, 64'd20);
        register_func(8'hFF);
        // Saturation of the call count needs 2^32 enters and is out of reach here.
    endtask

    task automatic test_register_active();
        register_func(8'h81);
        send_event(cpa_pkg::EV_ENTER, 8'h00, 64'd2000);
        send_event(cpa_pkg::EV_ENTER, 8'h81, 64'd2100);
        register_func(8'h81);                         // clears counters of a live frame
        send_event(cpa_pkg::EV_EXIT, 8'h81, 64'd2500);
        register_func(8'h00);
        send_event(cpa_pkg::EV_EXIT, 8'h00, 64'hAAAA_5555_AAAA_5555);
    endtask

    task automatic test_stack_overflow();
        register_func(8'h3C);
        while (path_level < CALL_DEPTH)
            send_event(cpa_pkg::EV_ENTER, 8'h3C, 64'(path_level * 7));
        send_event(cpa_pkg::EV_ENTER, 8'h3C, 64'd9999);
        send_event(cpa_pkg::EV_ENTER, 8'h00, 64'd10000);
        while (path_level > 0)
            send_event(cpa_pkg::EV_EXIT, 8'h3C, 64'(20000 + path_level));
    endtask

    task automatic test_random_traffic();
        trace_tick = {$urandom, $urandom};
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            sender_gaps = ((n / 100) % 3) != 2;
            sink_stalls = ((n / 130) % 4) != 3;
            random_event();
            if (n % 150 == 149)
                wait_for_results();
        end
    endtask

    task automatic test_back_to_back_tail();
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        for (int n = 0; n < TAIL_EVENTS; n++)
            random_event();
    endtask

    // Output side back-pressure in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0)
            stall_left--;
        else if (sink_stalls && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 9);
        m_axis_tready <= (stall_left == 0);
    end

    always @(posedge i_clk) begin
        t_profile_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_profiles.size() == 0) begin
                $error("result transaction with no event outstanding");
                mismatches++;
            end else begin
                want = expected_profiles.pop_front();
                check_field("status", TS_W'(want.status), TS_W'(m_axis_tuser));
                check_field("call_count", TS_W'(want.calls), TS_W'(m_axis_tdata[CALLS_W-1:0]));
                check_field("inclusive_time", want.incl, m_axis_tdata[CALLS_W +: TS_W]);
                check_field("exclusive_time", want.excl,
                            m_axis_tdata[CALLS_W + TS_W +: TS_W]);
                check_field("path_depth", TS_W'(want.depth),
                            TS_W'(m_axis_tdata[CALLS_W + 2 * TS_W +: DEPTH_W]));
            end
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("call_profile_accumulator regression: fail");
            $finish;
        end
    end

    initial begin
        path_level = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_refused_events();
        test_nesting();
        test_register_active();
        test_stack_overflow();
        test_random_traffic();
        test_back_to_back_tail();
        s_axis_tvalid <= 1'b0;
        while (expected_profiles.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_profiles.size() == 0) begin
            $display("call_profile_accumulator regression: pass");
        end else begin
            $display("call_profile_accumulator regression: fail");
        end
        $finish;
    end

endmodule
